>>> hw/rtl/tsb_pkg.sv
// Shared types, constants and helpers for the bilinear texture sampler.
package tsb_pkg;

  localparam int unsigned TexelDepth = 65536;
  localparam int unsigned AddrW      = $clog2(TexelDepth);

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_NEAREST  = 2'd1;
  localparam logic [1:0] OP_BILINEAR = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One axis after coordinate processing.
  typedef struct packed {
    logic [10:0] base;
    logic [10:0] nb;
    logic [16:0] w_base;
    logic [16:0] w_nb;
  } axis_t;

  // Control that travels beside an item through the pipeline.
  typedef struct packed {
    logic       valid;
  } ctl_t;

endpackage

>>> hw/rtl/tsb_axis.sv
// One coordinate axis: clamp, scale by the texture size and pick the neighbours.
module tsb_axis (
  input  logic                clk,
  input  logic                en,
  input  logic signed [17:0]  coord,
  input  logic [10:0]         size,
  input  logic [15:0]         half_off,
  input  logic                bilinear,
  output tsb_pkg::axis_t      axis
);
  import tsb_pkg::*;

  // Stage A: clamp and register; stage B: multiply and register; then decode.
  logic signed [18:0] sum;
  logic [16:0]        clamped;
  logic [16:0]        clamped_q;
  logic [10:0]        size_q;
  logic [10:0]        mult_size;
  logic [27:0]        prod;
  logic [27:0]        prod_q;
  logic [10:0]        size_q2;
  logic               bil_q, bil_q2;
  logic [10:0]        idx;
  logic [15:0]        fr;

  always_comb begin
    if (bilinear) sum = 19'(coord) + $signed({3'b000, half_off});
    else sum = 19'(coord);
    if (sum[18]) clamped = '0;
    else if (bilinear && sum > 19'sd65536) clamped = 17'd65536;
    else clamped = sum[16:0];
  end

  // Nearest values reach 2^17-1; scaling by size fits in 28 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      clamped_q <= clamped;
      size_q    <= size;
      bil_q     <= bilinear;
      prod_q    <= prod;
      size_q2   <= size_q;
      bil_q2    <= bil_q;
    end
  end

  assign mult_size = bil_q ? size_q - 11'd1 : size_q;
  assign prod      = 28'(clamped_q) * 28'(mult_size);

  always_comb begin
    fr  = prod_q[15:0];
    idx = (prod_q[27:16] >= 12'(size_q2)) ? size_q2 - 11'd1 : prod_q[26:16];
    axis.base = bil_q2 ? prod_q[26:16] : idx;
    if (!bil_q2) begin
      axis.nb   = idx;
      axis.w_nb = '0;
    end else if (fr > 16'd32768) begin
      axis.nb   = prod_q[26:16] + 11'd1;
      axis.w_nb = 17'(fr - 16'd32768);
    end else begin
      axis.nb   = (prod_q[26:16] != 11'd0) ? prod_q[26:16] - 11'd1 : prod_q[26:16];
      axis.w_nb = 17'(16'd32768 - fr);
    end
    axis.w_base = 17'd65536 - axis.w_nb;
  end

endmodule

>>> hw/rtl/tsb_bank.sv
// One copy of the texel memory, with one registered read port.
module tsb_bank (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tsb_pkg::AddrW-1:0]  waddr,
  input  logic [31:0]                wdata,
  input  logic                       re,
  input  logic [tsb_pkg::AddrW-1:0]  raddr,
  output logic [31:0]                rdata
);
  import tsb_pkg::*;

  logic [31:0] mem [TexelDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tsb_blend.sv
// Per-lane two-step blend: rows at full precision, then columns, then rounding.
module tsb_blend (
  input  logic         clk,
  input  logic         en,
  input  logic [31:0]  t00,
  input  logic [31:0]  t10,
  input  logic [31:0]  t01,
  input  logic [31:0]  t11,
  input  logic [16:0]  wx0,
  input  logic [16:0]  wx1,
  input  logic [16:0]  wy0,
  input  logic [16:0]  wy1,
  output logic [63:0]  chans
);
  import tsb_pkg::*;

  logic [3:0][24:0] r0, r1;
  logic [3:0][24:0] r0_q, r1_q;
  logic [16:0]      wy0_q, wy1_q;
  logic [3:0][41:0] pa, pb;
  logic [3:0][41:0] pa_q, pb_q;
  logic [3:0][42:0] acc;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r0[k] = 25'(t00[8*k +: 8]) * 25'(wx0) + 25'(t10[8*k +: 8]) * 25'(wx1);
      r1[k] = 25'(t01[8*k +: 8]) * 25'(wx0) + 25'(t11[8*k +: 8]) * 25'(wx1);
      pa[k] = 42'(r0_q[k]) * 42'(wy0_q);
      pb[k] = 42'(r1_q[k]) * 42'(wy1_q);
      acc[k] = 43'(pa_q[k]) + 43'(pb_q[k]) + 43'(24'h800000);
      chans[16*k +: 16] = acc[k][39:24];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_q  <= r0;
      r1_q  <= r1;
      wy0_q <= wy0;
      wy1_q <= wy1;
      pa_q  <= pa;
      pb_q  <= pb;
    end
  end

endmodule

>>> hw/rtl/texture_sampler_bilinear.sv
// Top level of the bilinear / nearest texture sampler.
//
// Usage: items arrive on the s_axis stream. A write item (op 0) stores one
// 32-bit texel at texel_index and gives no result. A nearest (op 1) or
// bilinear (op 2) sample item gives one result on the m_axis stream: four
// byte lanes in 8.8 fixed point. Op 3 is dropped. The texture size is set
// through the cfg write port (index 0 width, 1 height) while idle.
// The pipeline has eight register stages: clamp, scale, neighbour decode,
// address, texel read from four memory copies (one per neighbour), row
// blends, column blend with rounding, then the output register. One item per
// cycle is taken sustained while the receiver does not stall and no offsets
// are being recomputed. Writes travel down the first four stages and
// reach all four copies in the stage where samples read, so a sample sees
// exactly the writes that came before it.
// When the receiver stalls the whole pipeline holds; s_axis_tready is low
// while the output register holds an untaken result. After reset and after
// each size write the half-texel offsets are recomputed, with s_axis_tready
// low. Reset clears every valid bit and sets both sizes to one; the texel
// memory is not cleared and unwritten texels read as anything.
module texture_sampler_bilinear (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: op[1:0], texel_index[17:2], texel_value[49:18], coord_u[67:50],
  // coord_v[85:68], zero pad to 88 bits.
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: chan_0[15:0], chan_1[31:16], chan_2[47:32], chan_3[63:48].
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import tsb_pkg::*;

  localparam int Stages = 7;
  localparam logic [4:0] DivSteps = 5'd16;

  logic [10:0] tex_width, tex_height, eff_w, eff_h;
  logic [15:0] half_w, half_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= 11'd1;
      tex_height <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  tex_width  <= cfg_data;
        REG_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one.
  assign eff_w = (tex_width  == 11'd0) ? 11'd1 : tex_width;
  assign eff_h = (tex_height == 11'd0) ? 11'd1 : tex_height;

  // The half-texel offsets floor(32768 / size) come from a restoring
  // shift-subtract loop, one quotient bit per cycle, restarted by reset and
  // by every register write. Only bit 15 of the dividend is set.
  logic [4:0]  div_cnt;
  logic        div_busy, div_bit;
  logic [11:0] rem_w, rem_h, rem_w_sh, rem_h_sh;

  assign div_busy = (div_cnt != 5'd0);
  assign div_bit  = (div_cnt == DivSteps);
  assign rem_w_sh = {rem_w[10:0], div_bit};
  assign rem_h_sh = {rem_h[10:0], div_bit};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      div_cnt <= DivSteps;
      rem_w   <= '0;
      rem_h   <= '0;
      half_w  <= '0;
      half_h  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt - 5'd1;
      if (rem_w_sh >= {1'b0, eff_w}) begin
        rem_w  <= rem_w_sh - {1'b0, eff_w};
        half_w <= {half_w[14:0], 1'b1};
      end else begin
        rem_w  <= rem_w_sh;
        half_w <= {half_w[14:0], 1'b0};
      end
      if (rem_h_sh >= {1'b0, eff_h}) begin
        rem_h  <= rem_h_sh - {1'b0, eff_h};
        half_h <= {half_h[14:0], 1'b1};
      end else begin
        rem_h  <= rem_h_sh;
        half_h <= {half_h[14:0], 1'b0};
      end
    end
  end

  // Input fields.
  logic [1:0]         op;
  logic [15:0]        texel_index;
  logic [31:0]        texel_value;
  logic signed [17:0] coord_u, coord_v;
  assign op          = s_axis_tdata[1:0];
  assign texel_index = s_axis_tdata[17:2];
  assign texel_value = s_axis_tdata[49:18];
  assign coord_u     = s_axis_tdata[67:50];
  assign coord_v     = s_axis_tdata[85:68];

  // Pipeline advance: all stages move together unless the output is blocked.
  // New transfers also wait while the offsets are being recomputed.
  logic   en;
  ctl_t   ctl [Stages];
  logic   accept, is_sample;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !div_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_sample     = (op == OP_NEAREST) || (op == OP_BILINEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Stages; i++) ctl[i].valid <= 1'b0;
    end else if (en) begin
      ctl[0].valid <= accept && is_sample;
      for (int i = 1; i < Stages; i++) ctl[i].valid <= ctl[i-1].valid;
    end
  end

  // Stages 1 and 2: axis units (two internal register stages each).
  axis_t ax_u, ax_v;
  logic  bil_in;
  assign bil_in = (op == OP_BILINEAR);

  tsb_axis u_axis_u (
    .clk(clk), .en(en), .coord(coord_u), .size(eff_w), .half_off(half_w),
    .bilinear(bil_in), .axis(ax_u)
  );
  tsb_axis u_axis_v (
    .clk(clk), .en(en), .coord(coord_v), .size(eff_h), .half_off(half_h),
    .bilinear(bil_in), .axis(ax_v)
  );

  // Stage 3: row products, weights registered.
  logic [21:0] row0, row1;
  axis_t       ax_u3, ax_v3;
  always_ff @(posedge clk) begin
    if (en) begin
      row0  <= 22'(eff_w) * 22'(ax_v.base);
      row1  <= 22'(eff_w) * 22'(ax_v.nb);
      ax_u3 <= ax_u;
      ax_v3 <= ax_v;
    end
  end

  // Stage 4: four addresses, wrapped modulo the memory depth.
  logic [AddrW-1:0] a00, a10, a01, a11;
  axis_t            ax_u4, ax_v4;
  always_ff @(posedge clk) begin
    if (en) begin
      a00   <= AddrW'(row0 + 22'(ax_u3.base));
      a10   <= AddrW'(row0 + 22'(ax_u3.nb));
      a01   <= AddrW'(row1 + 22'(ax_u3.base));
      a11   <= AddrW'(row1 + 22'(ax_u3.nb));
      ax_u4 <= ax_u3;
      ax_v4 <= ax_v3;
    end
  end

  // Writes are delayed by four stages so that they land in the memory at the
  // same point where samples read it, keeping the transfer order.
  logic             wr;
  logic             wr_commit;
  logic [3:0]       wr_pipe;
  logic [AddrW-1:0] wr_index_pipe [4];
  logic [31:0]      wr_value_pipe [4];
  assign wr        = accept && (op == OP_WRITE);
  assign wr_commit = wr_pipe[3] && en;

  always_ff @(posedge clk) begin
    if (rst) wr_pipe <= '0;
    else if (en) wr_pipe <= {wr_pipe[2:0], wr};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_index_pipe[0] <= texel_index;
      wr_value_pipe[0] <= texel_value;
      for (int i = 1; i < 4; i++) begin
        wr_index_pipe[i] <= wr_index_pipe[i-1];
        wr_value_pipe[i] <= wr_value_pipe[i-1];
      end
    end
  end

  // Stage 5: texel read from four memory copies.
  logic [31:0] t00, t10, t01, t11;
  axis_t       ax_u5, ax_v5;

  tsb_bank u_bank00 (.clk(clk), .we(wr_commit), .waddr(wr_index_pipe[3]),
                     .wdata(wr_value_pipe[3]), .re(en), .raddr(a00), .rdata(t00));
  tsb_bank u_bank10 (.clk(clk), .we(wr_commit), .waddr(wr_index_pipe[3]),
                     .wdata(wr_value_pipe[3]), .re(en), .raddr(a10), .rdata(t10));
  tsb_bank u_bank01 (.clk(clk), .we(wr_commit), .waddr(wr_index_pipe[3]),
                     .wdata(wr_value_pipe[3]), .re(en), .raddr(a01), .rdata(t01));
  tsb_bank u_bank11 (.clk(clk), .we(wr_commit), .waddr(wr_index_pipe[3]),
                     .wdata(wr_value_pipe[3]), .re(en), .raddr(a11), .rdata(t11));

  always_ff @(posedge clk) begin
    if (en) begin
      ax_u5 <= ax_u4;
      ax_v5 <= ax_v4;
    end
  end

  // Stages 6 and 7: blend. Nearest mode gets weight one on the base texel,
  // which yields the byte shifted up by eight after rounding.
  logic [63:0] chans;
  tsb_blend u_blend (
    .clk(clk), .en(en), .t00(t00), .t10(t10), .t01(t01), .t11(t11),
    .wx0(ax_u5.w_base), .wx1(ax_u5.w_nb), .wy0(ax_v5.w_base), .wy1(ax_v5.w_nb),
    .chans(chans)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= ctl[Stages-1].valid;
  end

  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= chans;
  end

endmodule
